### sv/trsp_pkg.sv
`timescale 1ns / 1ps

package trsp_pkg;

    typedef enum logic [3:0] {
        PH_CNT_LO    = 4'd0,
        PH_CNT_HI    = 4'd1,
        PH_NAME_LEN  = 4'd2,
        PH_NAME_SKIP = 4'd3,
        PH_TAG       = 4'd4,
        PH_INT       = 4'd5,
        PH_FLOAT     = 4'd6,
        PH_LEN_LO    = 4'd7,
        PH_LEN_HI    = 4'd8,
        PH_TEXT      = 4'd9,
        PH_CAPPED    = 4'd10,
        PH_IDLE      = 4'd11
    } phase_t;

    typedef logic [1:0] event_t;
    typedef logic [2:0] kind_t;

    localparam event_t EV_HEADER = 2'd0;
    localparam event_t EV_CHAR   = 2'd1;
    localparam event_t EV_CELL   = 2'd2;
    localparam event_t EV_CAPPED = 2'd3;

    localparam kind_t K_NULL    = 3'd0;
    localparam kind_t K_INT     = 3'd1;
    localparam kind_t K_INT_OVF = 3'd2;
    localparam kind_t K_FLOAT   = 3'd3;
    localparam kind_t K_TEXT    = 3'd4;
    localparam kind_t K_BLOB    = 3'd5;
    localparam kind_t K_BAD     = 3'd6;

    localparam logic [7:0] TC_NULL  = 8'd0;
    localparam logic [7:0] TC_INT   = 8'd1;
    localparam logic [7:0] TC_FLOAT = 8'd2;
    localparam logic [7:0] TC_TEXT  = 8'd3;
    localparam logic [7:0] TC_BLOB  = 8'd4;

    localparam logic REG_MAX_ROWS       = 1'b0;
    localparam logic REG_MAX_CELL_CHARS = 1'b1;

    localparam logic [7:0] MAX_ROWS_RESET       = 8'd50;
    localparam logic [7:0] MAX_CELL_CHARS_RESET = 8'd39;
    localparam logic [7:0] SIGN_FILL            = 8'hFF;
    localparam logic [15:0] WIDE_BYTES          = 16'd8;

endpackage

### sv/tagged_result_stream_parser_unit.sv
`timescale 1ns / 1ps

// byte-serial parser for a tagged query result stream
// input channel s_*: one stream byte per word, s_tuser = 1 restarts parsing at
// the header with all counts cleared (applies to the byte it comes with)
// output channel m_*: at most one event word per input byte; event and cell
// kind in m_tuser, value / char / column / row in m_tdata, m_tlast marks the
// cell done event that closes a row
// configuration: cfg_we writes cfg_data into register cfg_index (0 max_rows,
// 1 max_cell_chars); the user must write only while the block is idle (unchecked)
// an accepted byte is loaded into the input register, and from there passes
// through the parser into the output register once the output register is free
// throughput: one byte per cycle while the receiver does not stall, limited by
// the single parser pass between the input and output registers
// when the receiver stalls with a word held, the input register still takes
// one more byte; further bytes wait in s_tready low until m_tready returns
// reset: parser back at the header, both registers at their defaults
// (max_rows 50, max_cell_chars 39), both channels empty
module tagged_result_stream_parser_unit
    import trsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // start_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value[31:0], char_byte, column_index, row_index
    output logic [4:0]  m_tuser,   // event_res[1:0], cell_kind[2:0]
    output logic        m_tlast,   // last_in_row
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]  max_rows_reg;
    logic [7:0]  max_cell_chars_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_sos_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] column_count_reg, column_count_next;
    logic [15:0] names_left_reg, names_left_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] current_column_reg, current_column_next;
    logic [7:0]  rows_stored_reg, rows_stored_next;
    logic [31:0] integer_low_reg, integer_low_next;
    logic [1:0]  high_sign_ok_reg, high_sign_ok_next;
    logic [7:0]  chars_emitted_reg, chars_emitted_next;
    logic        is_blob_reg, is_blob_next;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [4:0]  out_user_reg;
    logic        out_last_reg;

    // state as seen by this byte, after an optional restart
    phase_t      ph;
    logic [15:0] col_cnt;
    logic [15:0] names_left;
    logic [15:0] bytes_left;
    logic [15:0] cur_col;
    logic [7:0]  rows;
    logic [31:0] int_low;
    logic [1:0]  hso;
    logic [7:0]  chars;
    logic        blob;
    logic [7:0]  b;

    logic [15:0] cnt_full;
    logic [15:0] len_full;
    logic [15:0] names_dec;
    logic [15:0] bytes_dec;
    logic [15:0] col_inc;
    logic [7:0]  row_inc;
    logic [7:0]  chars_inc;
    logic        row_closes;
    logic        cap_hit;
    logic        keep;
    logic [2:0]  int_idx;
    logic [1:0]  hso_new;
    logic [31:0] int_new;
    logic        int_ok;
    kind_t       text_kind;
    phase_t      cell_target;
    phase_t      hdr_target;

    logic        res_valid;
    event_t      res_ev;
    kind_t       res_kind;
    logic [31:0] res_value;
    logic [7:0]  res_char;
    logic [15:0] res_col;
    logic [7:0]  res_row;
    logic        res_last;
    logic        cell_fire;

    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        b          = in_byte_reg;
        ph         = in_sos_reg ? PH_CNT_LO : phase_reg;
        col_cnt    = in_sos_reg ? 16'd0 : column_count_reg;
        names_left = in_sos_reg ? 16'd0 : names_left_reg;
        bytes_left = in_sos_reg ? 16'd0 : bytes_left_reg;
        cur_col    = in_sos_reg ? 16'd0 : current_column_reg;
        rows       = in_sos_reg ? 8'd0 : rows_stored_reg;
        int_low    = in_sos_reg ? 32'd0 : integer_low_reg;
        hso        = in_sos_reg ? 2'b11 : high_sign_ok_reg;
        chars      = in_sos_reg ? 8'd0 : chars_emitted_reg;
        blob       = in_sos_reg ? 1'b0 : is_blob_reg;

        cnt_full   = {b, col_cnt[7:0]};
        len_full   = {b, bytes_left[7:0]};
        names_dec  = names_left - 16'd1;
        bytes_dec  = bytes_left - 16'd1;
        col_inc    = cur_col + 16'd1;
        row_inc    = rows + 8'd1;
        chars_inc  = chars + 8'd1;
        row_closes = col_inc >= col_cnt;
        cap_hit    = row_inc >= max_rows_reg;
        keep       = chars < max_cell_chars_reg;
        int_idx    = 3'(WIDE_BYTES - bytes_left);
        text_kind  = blob ? K_BLOB : K_TEXT;

        int_new = int_low;
        hso_new = hso;
        if (!int_idx[2])
        begin
            case (int_idx[1:0])
                2'd0:    int_new[7:0]   = int_low[7:0] | b;
                2'd1:    int_new[15:8]  = int_low[15:8] | b;
                2'd2:    int_new[23:16] = int_low[23:16] | b;
                default: int_new[31:24] = int_low[31:24] | b;
            endcase
        end
        else
        begin
            if (b != 8'h00)
                hso_new[0] = 1'b0;
            if (b != SIGN_FILL)
                hso_new[1] = 1'b0;
        end
        int_ok = int_new[31] ? hso_new[1] : hso_new[0];

        cell_target = (row_closes && cap_hit) ? PH_CAPPED : PH_TAG;
        hdr_target  = (col_cnt == 16'd0) ? PH_IDLE : PH_TAG;
    end

    // next phase
    always_comb
    begin
        phase_next = ph;
        unique case (ph)
            PH_CNT_LO:
                phase_next = PH_CNT_HI;
            PH_CNT_HI:
                phase_next = (cnt_full == 16'd0) ? PH_IDLE : PH_NAME_LEN;
            PH_NAME_LEN:
                if (b != 8'd0)
                    phase_next = PH_NAME_SKIP;
                else if (names_dec == 16'd0)
                    phase_next = hdr_target;
            PH_NAME_SKIP:
                if (bytes_dec == 16'd0)
                    phase_next = (names_dec == 16'd0) ? hdr_target : PH_NAME_LEN;
            PH_TAG:
                case (b)
                    TC_INT:   phase_next = PH_INT;
                    TC_FLOAT: phase_next = PH_FLOAT;
                    TC_TEXT, TC_BLOB: phase_next = PH_LEN_LO;
                    default:  phase_next = cell_target;
                endcase
            PH_INT, PH_FLOAT, PH_TEXT:
                if (bytes_dec == 16'd0)
                    phase_next = cell_target;
            PH_LEN_LO:
                phase_next = PH_LEN_HI;
            PH_LEN_HI:
                phase_next = (len_full == 16'd0) ? cell_target : PH_TEXT;
            PH_CAPPED:
                phase_next = PH_IDLE;
            PH_IDLE:
                phase_next = PH_IDLE;
            default:
                phase_next = PH_IDLE;
        endcase
    end

    // datapath and event
    always_comb
    begin
        column_count_next   = col_cnt;
        names_left_next     = names_left;
        bytes_left_next     = bytes_left;
        current_column_next = cur_col;
        rows_stored_next    = rows;
        integer_low_next    = int_low;
        high_sign_ok_next   = hso;
        chars_emitted_next  = chars;
        is_blob_next        = blob;

        res_valid = 1'b0;
        res_ev    = EV_HEADER;
        res_kind  = K_NULL;
        res_value = 32'd0;
        res_char  = 8'd0;
        res_col   = 16'd0;
        res_row   = 8'd0;
        res_last  = 1'b0;
        cell_fire = 1'b0;

        unique case (ph)
            PH_CNT_LO:
                column_count_next = {8'd0, b};
            PH_CNT_HI:
            begin
                column_count_next = cnt_full;
                names_left_next   = cnt_full;
                if (cnt_full == 16'd0)
                begin
                    res_valid           = 1'b1;
                    current_column_next = 16'd0;
                end
            end
            PH_NAME_LEN:
                if (b != 8'd0)
                    bytes_left_next = {8'd0, b};
                else
                begin
                    names_left_next = names_dec;
                    if (names_dec == 16'd0)
                    begin
                        res_valid           = 1'b1;
                        res_value           = {16'd0, col_cnt};
                        current_column_next = 16'd0;
                    end
                end
            PH_NAME_SKIP:
            begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    names_left_next = names_dec;
                    if (names_dec == 16'd0)
                    begin
                        res_valid           = 1'b1;
                        res_value           = {16'd0, col_cnt};
                        current_column_next = 16'd0;
                    end
                end
            end
            PH_TAG:
                case (b)
                    TC_NULL:
                    begin
                        cell_fire = 1'b1;
                        res_kind  = K_NULL;
                    end
                    TC_INT:
                    begin
                        integer_low_next  = 32'd0;
                        high_sign_ok_next = 2'b11;
                        bytes_left_next   = WIDE_BYTES;
                    end
                    TC_FLOAT:
                        bytes_left_next = WIDE_BYTES;
                    TC_TEXT, TC_BLOB:
                        is_blob_next = (b == TC_BLOB);
                    default:
                    begin
                        cell_fire = 1'b1;
                        res_kind  = K_BAD;
                        res_value = {24'd0, b};
                    end
                endcase
            PH_INT:
            begin
                integer_low_next  = int_new;
                high_sign_ok_next = hso_new;
                bytes_left_next   = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    cell_fire = 1'b1;
                    res_kind  = int_ok ? K_INT : K_INT_OVF;
                    res_value = int_new;
                end
            end
            PH_FLOAT:
            begin
                bytes_left_next = bytes_dec;
                if (bytes_dec == 16'd0)
                begin
                    cell_fire = 1'b1;
                    res_kind  = K_FLOAT;
                end
            end
            PH_LEN_LO:
                bytes_left_next = {8'd0, b};
            PH_LEN_HI:
            begin
                bytes_left_next    = len_full;
                chars_emitted_next = 8'd0;
                if (len_full == 16'd0)
                begin
                    cell_fire = 1'b1;
                    res_kind  = text_kind;
                end
            end
            PH_TEXT:
            begin
                bytes_left_next = bytes_dec;
                if (keep)
                    chars_emitted_next = chars_inc;
                if (bytes_dec == 16'd0)
                begin
                    cell_fire = 1'b1;
                    res_kind  = text_kind;
                    res_value = {24'd0, keep ? chars_inc : chars};
                    res_char  = keep ? b : 8'd0;
                end
                else if (keep)
                begin
                    res_valid = 1'b1;
                    res_ev    = EV_CHAR;
                    res_kind  = text_kind;
                    res_char  = b;
                    res_col   = cur_col;
                    res_row   = rows;
                end
            end
            PH_CAPPED:
            begin
                res_valid = 1'b1;
                res_ev    = EV_CAPPED;
                res_row   = rows;
            end
            PH_IDLE:
                res_valid = 1'b0;
            default:
                res_valid = 1'b0;
        endcase

        if (cell_fire)
        begin
            res_valid = 1'b1;
            res_ev    = EV_CELL;
            res_col   = cur_col;
            res_row   = rows;
            res_last  = row_closes;
            if (row_closes)
            begin
                current_column_next = 16'd0;
                rows_stored_next    = row_inc;
            end
            else
                current_column_next = col_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rows_reg       <= MAX_ROWS_RESET;
            max_cell_chars_reg <= MAX_CELL_CHARS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ROWS:       max_rows_reg <= cfg_data;
                REG_MAX_CELL_CHARS: max_cell_chars_reg <= cfg_data;
                default:            max_rows_reg <= max_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_sos_reg  <= s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_CNT_LO;
            column_count_reg   <= 16'd0;
            names_left_reg     <= 16'd0;
            bytes_left_reg     <= 16'd0;
            current_column_reg <= 16'd0;
            rows_stored_reg    <= 8'd0;
            integer_low_reg    <= 32'd0;
            high_sign_ok_reg   <= 2'b11;
            chars_emitted_reg  <= 8'd0;
            is_blob_reg        <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            column_count_reg   <= column_count_next;
            names_left_reg     <= names_left_next;
            bytes_left_reg     <= bytes_left_next;
            current_column_reg <= current_column_next;
            rows_stored_reg    <= rows_stored_next;
            integer_low_reg    <= integer_low_next;
            high_sign_ok_reg   <= high_sign_ok_next;
            chars_emitted_reg  <= chars_emitted_next;
            is_blob_reg        <= is_blob_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_data_reg <= {res_row, res_col, res_char, res_value};
            out_user_reg <= {res_kind, res_ev};
            out_last_reg <= res_last;
        end
    end

endmodule

### sv/trsp_checker.sv
`timescale 1ns / 1ps

module trsp_checker
    import trsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output word changed while stalled");

    // only a cell done closes a row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1:0] == EV_CELL)
    else $error("last_in_row on an event other than cell done");

    // capped and header events carry no cell kind and no column
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] == EV_CAPPED || m_tuser[1:0] == EV_HEADER)
            |-> m_tuser[4:2] == K_NULL && m_tdata[55:40] == 16'd0
                && m_tdata[39:32] == 8'd0)
    else $error("header or capped event with cell fields set");

    // character events come only from text or blob cells
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == EV_CHAR
            |-> (m_tuser[4:2] == K_TEXT || m_tuser[4:2] == K_BLOB)
                && m_tdata[31:0] == 32'd0)
    else $error("character event with wrong kind or value");

    // a stalled output leaves room for at most one more buffered word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && s_tvalid && s_tready |=> !s_tready || m_tready)
    else $error("input taken while both stages are full");

endmodule

bind tagged_result_stream_parser_unit trsp_checker u_trsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import trsp_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       sos;
    } stream_byte_t;

    typedef struct {
        event_t      ev;
        kind_t       kind;
        logic [31:0] value;
        logic [7:0]  ch;
        logic [15:0] col;
        logic [7:0]  row;
        logic        last;
    } parse_event_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;

    tagged_result_stream_parser_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stream_byte_t pending_bytes[$];
    parse_event_t expected_events[$];

    int mismatches = 0;
    int pushed = 0;
    int budget = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit long_ok = 1'b0;

    // local copy of the registers
    logic [7:0] cap_rows = MAX_ROWS_RESET;
    logic [7:0] cap_chars = MAX_CELL_CHARS_RESET;

    // parser state
    phase_t      ph = PH_CNT_LO;
    logic [15:0] col_count = 16'd0;
    logic [15:0] names_left = 16'd0;
    logic [15:0] bytes_left = 16'd0;
    logic [15:0] cur_col = 16'd0;
    logic [7:0]  rows_done = 8'd0;
    logic [31:0] int_low = 32'd0;
    logic [1:0]  sign_ok = 2'b11;
    logic [7:0]  chars_kept = 8'd0;
    logic        blob_cell = 1'b0;

    // {start_of_stream, data_byte}
    logic [8:0] directed_bytes [0:22] = '{
        9'h100, 9'h000, 9'h07E,
        9'h101, 9'h000, 9'h000,
        9'h001, 9'h000, 9'h000, 9'h000, 9'h080, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
        9'h003, 9'h000, 9'h000,
        9'h0FF,
        9'h004, 9'h001, 9'h000, 9'h041
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_event(input event_t ev, input kind_t k, input logic [31:0] v,
                              input logic [7:0] c, input logic [15:0] col,
                              input logic [7:0] row, input logic last);
        parse_event_t w;
        w.ev = ev;
        w.kind = k;
        w.value = v;
        w.ch = c;
        w.col = col;
        w.row = row;
        w.last = last;
        expected_events.push_back(w);
    endtask

    task automatic finish_header();
        cur_col = 16'd0;
        ph = (col_count == 16'd0) ? PH_IDLE : PH_TAG;
        push_event(EV_HEADER, K_NULL, {16'd0, col_count}, 8'd0, 16'd0, 8'd0, 1'b0);
    endtask

    task automatic close_cell(input kind_t k, input logic [31:0] v, input logic [7:0] c);
        logic [15:0] col;
        logic [7:0]  row;
        logic        last;
        col = cur_col;
        row = rows_done;
        last = 1'b0;
        ph = PH_TAG;
        cur_col = cur_col + 16'd1;
        if (cur_col >= col_count)
        begin
            last = 1'b1;
            cur_col = 16'd0;
            rows_done = rows_done + 8'd1;
            if (rows_done >= cap_rows)
                ph = PH_CAPPED;
        end
        push_event(EV_CELL, k, v, c, col, row, last);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sos);
        logic [15:0] pos;
        logic        keep;
        kind_t       text_kind;
        if (sos)
        begin
            ph = PH_CNT_LO;
            col_count = 16'd0;
            names_left = 16'd0;
            bytes_left = 16'd0;
            cur_col = 16'd0;
            rows_done = 8'd0;
            int_low = 32'd0;
            sign_ok = 2'b11;
            chars_kept = 8'd0;
            blob_cell = 1'b0;
        end
        text_kind = blob_cell ? K_BLOB : K_TEXT;
        case (ph)
            PH_CNT_LO:
            begin
                col_count = {8'd0, b};
                ph = PH_CNT_HI;
            end
            PH_CNT_HI:
            begin
                col_count[15:8] = b;
                names_left = col_count;
                if (names_left == 16'd0)
                    finish_header();
                else
                    ph = PH_NAME_LEN;
            end
            PH_NAME_LEN:
            begin
                if (b != 8'd0)
                begin
                    bytes_left = {8'd0, b};
                    ph = PH_NAME_SKIP;
                end
                else
                begin
                    names_left = names_left - 16'd1;
                    if (names_left == 16'd0)
                        finish_header();
                end
            end
            PH_NAME_SKIP:
            begin
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                begin
                    names_left = names_left - 16'd1;
                    if (names_left == 16'd0)
                        finish_header();
                    else
                        ph = PH_NAME_LEN;
                end
            end
            PH_TAG:
            begin
                if (b == TC_NULL)
                    close_cell(K_NULL, 32'd0, 8'd0);
                else if (b == TC_INT)
                begin
                    int_low = 32'd0;
                    sign_ok = 2'b11;
                    bytes_left = WIDE_BYTES;
                    ph = PH_INT;
                end
                else if (b == TC_FLOAT)
                begin
                    bytes_left = WIDE_BYTES;
                    ph = PH_FLOAT;
                end
                else if (b == TC_TEXT || b == TC_BLOB)
                begin
                    blob_cell = (b == TC_BLOB);
                    ph = PH_LEN_LO;
                end
                else
                    close_cell(K_BAD, {24'd0, b}, 8'd0);
            end
            PH_INT:
            begin
                pos = WIDE_BYTES - bytes_left;
                if (!pos[2])
                    int_low[8 * pos[1:0] +: 8] = b;
                else
                begin
                    if (b != 8'h00)
                        sign_ok[0] = 1'b0;
                    if (b != SIGN_FILL)
                        sign_ok[1] = 1'b0;
                end
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                begin
                    if (int_low[31] ? sign_ok[1] : sign_ok[0])
                        close_cell(K_INT, int_low, 8'd0);
                    else
                        close_cell(K_INT_OVF, int_low, 8'd0);
                end
            end
            PH_FLOAT:
            begin
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    close_cell(K_FLOAT, 32'd0, 8'd0);
            end
            PH_LEN_LO:
            begin
                bytes_left = {8'd0, b};
                ph = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                bytes_left[15:8] = b;
                chars_kept = 8'd0;
                if (bytes_left == 16'd0)
                    close_cell(text_kind, 32'd0, 8'd0);
                else
                    ph = PH_TEXT;
            end
            PH_TEXT:
            begin
                bytes_left = bytes_left - 16'd1;
                keep = (chars_kept < cap_chars);
                if (keep)
                    chars_kept = chars_kept + 8'd1;
                if (bytes_left == 16'd0)
                    close_cell(text_kind, {24'd0, chars_kept}, keep ? b : 8'd0);
                else if (keep)
                    push_event(EV_CHAR, text_kind, 32'd0, b, cur_col, rows_done, 1'b0);
            end
            PH_CAPPED:
            begin
                ph = PH_IDLE;
                push_event(EV_CAPPED, K_NULL, 32'd0, 8'd0, 16'd0, rows_done, 1'b0);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // sender
    always @(posedge clk)
    begin
        stream_byte_t item;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tuser);
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() == 0)
                    s_tvalid <= 1'b0;
                else if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    item = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= item.data;
                    s_tuser <= item.sos;
                    send_gap = pick_gap();
                end
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        parse_event_t w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
                else
                begin
                    w = expected_events.pop_front();
                    check_field("event", {30'd0, m_tuser[1:0]}, {30'd0, w.ev});
                    check_field("cell kind", {29'd0, m_tuser[4:2]}, {29'd0, w.kind});
                    check_field("value", m_tdata[31:0], w.value);
                    check_field("char", {24'd0, m_tdata[39:32]}, {24'd0, w.ch});
                    check_field("column", {16'd0, m_tdata[55:40]}, {16'd0, w.col});
                    check_field("row", {24'd0, m_tdata[63:56]}, {24'd0, w.row});
                    check_field("last in row", {31'd0, m_tlast}, {31'd0, w.last});
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic sos);
        stream_byte_t item;
        if (budget > 0)
        begin
            item.data = b;
            item.sos = sos;
            pending_bytes.push_back(item);
            budget--;
            pushed++;
        end
    endtask

    task automatic gen_cell();
        int r;
        int len;
        logic [31:0] lo;
        logic [31:0] hi;
        r = $urandom_range(0, 99);
        if (r < 15)
            queue_byte(TC_NULL, 1'b0);
        else if (r < 40)
        begin
            lo = $urandom;
            case ($urandom_range(0, 3))
                0: hi = {32{lo[31]}};
                1: hi = ~{32{lo[31]}};
                2: hi = $urandom;
                default:
                begin
                    hi = {32{lo[31]}};
                    hi[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
                end
            endcase
            queue_byte(TC_INT, 1'b0);
            for (int i = 0; i < 4; i++)
                queue_byte(lo[8 * i +: 8], 1'b0);
            for (int i = 0; i < 4; i++)
                queue_byte(hi[8 * i +: 8], 1'b0);
        end
        else if (r < 50)
        begin
            queue_byte(TC_FLOAT, 1'b0);
            repeat (8) queue_byte(8'($urandom), 1'b0);
        end
        else if (r < 85)
        begin
            queue_byte($urandom_range(0, 1) ? TC_BLOB : TC_TEXT, 1'b0);
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 0;
            else if (long_ok && r < 14)
                len = $urandom_range(256, 300);
            else if (r < 70)
                len = $urandom_range(1, 8);
            else
                len = $urandom_range(9, 40);
            queue_byte(len[7:0], 1'b0);
            queue_byte(len[15:8], 1'b0);
            repeat (len) queue_byte(8'($urandom), 1'b0);
        end
        else
            queue_byte(8'($urandom_range(5, 255)), 1'b0);
    endtask

    task automatic gen_stream(input int ncols, input int nrows);
        int len;
        queue_byte(ncols[7:0], 1'b1);
        queue_byte(ncols[15:8], 1'b0);
        for (int c = 0; c < ncols; c++)
        begin
            if (ncols > 8 || $urandom_range(0, 3) == 0)
                len = 0;
            else
                len = $urandom_range(1, 5);
            queue_byte(len[7:0], 1'b0);
            repeat (len) queue_byte(8'($urandom), 1'b0);
        end
        repeat (nrows * ncols) gen_cell();
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_ROWS)
            cap_rows = val;
        else
            cap_chars = val;
    endtask

    // waits until every queued byte is sent and every expected word is back
    task automatic drain();
        while (pending_bytes.size() != 0 || s_tvalid || expected_events.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int target;
        int r;
        logic [7:0] rows_val;
        logic [7:0] chars_val;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // defaults, zero columns, empty name, extreme integer, empty text, bad tag
        budget = 1 << 30;
        for (int i = 0; i < 23; i++)
            queue_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    rows_val = 8'd1;
                    chars_val = 8'd0;
                end
                1:
                begin
                    rows_val = 8'd255;
                    chars_val = 8'd255;
                end
                3:
                begin
                    rows_val = 8'd2;
                    chars_val = 8'd4;
                end
                default:
                begin
                    rows_val = 8'($urandom_range(1, 8));
                    chars_val = 8'($urandom_range(0, 10));
                end
            endcase
            write_reg(REG_MAX_ROWS, rows_val);
            write_reg(REG_MAX_CELL_CHARS, chars_val);
            quiet = (p == 2);
            long_ok = (p == 1);

            // column count above one byte, cut after a few cells
            if (p == 3)
            begin
                r = $urandom_range(256, 260);
                budget = r + 2 + $urandom_range(5, 20);
                gen_stream(r, 1);
            end

            target = pushed + ((p == 1) ? 80 : 25);
            while (pushed < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    budget = (r < 63) ? (target - pushed) : $urandom_range(1, 40);
                    if (budget > target - pushed)
                        budget = target - pushed;
                    gen_stream($urandom_range(1, 4), $urandom_range(1, 6));
                end
                else if (r < 82)
                begin
                    budget = target - pushed;
                    gen_stream(0, 0);
                    repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b0);
                end
                else
                begin
                    budget = target - pushed;
                    repeat ($urandom_range(1, 10))
                        queue_byte(8'($urandom), $urandom_range(0, 9) == 0);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
